### rtl/rrts_pkg.sv
// Shared types and constants for the round-robin task scheduler.
// Used by rrts_ctrl, rrts_dp and round_robin_task_scheduler; no dependencies.
package rrts_pkg;

  localparam int unsigned MaxTasks = 16;
  localparam int unsigned IdW      = $clog2(MaxTasks);
  localparam int unsigned LenW     = $clog2(MaxTasks + 1);
  localparam int unsigned MsW      = 32;
  localparam int unsigned SliceW   = 8;
  localparam int unsigned PeriodW  = 10;
  localparam int unsigned DivCntW  = $clog2(MsW + 1);

  localparam logic [SliceW-1:0]  SliceRst  = SliceW'(10);
  localparam logic [PeriodW-1:0] PeriodRst = PeriodW'(10);

  // Event codes carried by the func field.
  localparam logic [2:0] FuncTick  = 3'd0;
  localparam logic [2:0] FuncReady = 3'd1;
  localparam logic [2:0] FuncYield = 3'd2;
  localparam logic [2:0] FuncSleep = 3'd3;
  localparam logic [2:0] FuncBlock = 3'd4;

  // Configuration register indexes.
  localparam logic CfgTimeSlice  = 1'b0;
  localparam logic CfgTickPeriod = 1'b1;

  typedef enum logic [5:0] {
    StIdle   = 6'b000001,
    StDecode = 6'b000010,
    StWalk   = 6'b000100,
    StDiv    = 6'b001000,
    StApply  = 6'b010000,
    StDone   = 6'b100000
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic exec;
    logic tick_slice;
    logic walk_start;
    logic walk_step;
    logic walk_end;
    logic div_start;
    logic div_step;
    logic sleep_apply;
    logic finish;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_tick;
    logic is_sleep;
    logic walk_done;
    logic div_done;
  } status_t;

endpackage

### rtl/rrts_ctrl.sv
// Controller state machine of the round-robin task scheduler.
// Depends on rrts_pkg; drives the rrts_dp datapath through cmd_t.
module rrts_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  input  rrts_pkg::status_t status_i,
  output rrts_pkg::cmd_t   cmd_o
);

  rrts_pkg::state_e state_q, state_d;
  logic out_valid_q, out_valid_d;

  // Next state and command decode.
  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    out_valid_d = out_valid_q && out_stall_i;
    case (state_q)
      rrts_pkg::StIdle: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = rrts_pkg::StDecode;
        end
      end
      rrts_pkg::StDecode: begin
        if (status_i.is_tick) begin
          cmd_o.tick_slice = 1'b1;
          cmd_o.walk_start = 1'b1;
          state_d          = rrts_pkg::StWalk;
        end else if (status_i.is_sleep) begin
          cmd_o.div_start = 1'b1;
          state_d         = rrts_pkg::StDiv;
        end else begin
          cmd_o.exec = 1'b1;
          state_d    = rrts_pkg::StDone;
        end
      end
      rrts_pkg::StWalk: begin
        if (status_i.walk_done) begin
          cmd_o.walk_end = 1'b1;
          state_d        = rrts_pkg::StDone;
        end else begin
          cmd_o.walk_step = 1'b1;
        end
      end
      rrts_pkg::StDiv: begin
        if (status_i.div_done) begin
          state_d = rrts_pkg::StApply;
        end else begin
          cmd_o.div_step = 1'b1;
        end
      end
      rrts_pkg::StApply: begin
        cmd_o.sleep_apply = 1'b1;
        state_d           = rrts_pkg::StDone;
      end
      rrts_pkg::StDone: begin
        // Dispatch only once the previous result has been taken.
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.finish = 1'b1;
          out_valid_d  = 1'b1;
          state_d      = rrts_pkg::StIdle;
        end
      end
      default: begin
        state_d = rrts_pkg::StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= rrts_pkg::StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != rrts_pkg::StIdle);
  assign out_valid_o = out_valid_q;

endmodule

### rtl/rrts_dp.sv
// Datapath of the round-robin task scheduler: ready queue, sleep list,
// slice counters, sleep divider and result registers. Depends on rrts_pkg.
module rrts_dp (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic                              cfg_idx_i,
  input  logic [rrts_pkg::PeriodW-1:0]      cfg_wdata_i,
  input  logic [2:0]                        func_i,
  input  logic [rrts_pkg::IdW-1:0]          task_id_i,
  input  logic                              fresh_i,
  input  logic [rrts_pkg::MsW-1:0]          sleep_ms_i,
  input  rrts_pkg::cmd_t                    cmd_i,
  output rrts_pkg::status_t                 status_o,
  output logic [rrts_pkg::IdW-1:0]          running_task_o,
  output logic                              running_is_idle_o,
  output logic                              switched_o,
  output logic [rrts_pkg::LenW-1:0]         ready_count_o
);

  localparam int unsigned N  = rrts_pkg::MaxTasks;
  localparam int unsigned IW = rrts_pkg::IdW;
  localparam int unsigned LW = rrts_pkg::LenW;
  localparam int unsigned MW = rrts_pkg::MsW;
  localparam int unsigned SW = rrts_pkg::SliceW;
  localparam int unsigned PW = rrts_pkg::PeriodW;

  // Configuration registers.
  logic [SW-1:0] time_slice_q;
  logic [PW-1:0] tick_period_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      time_slice_q  <= rrts_pkg::SliceRst;
      tick_period_q <= rrts_pkg::PeriodRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        rrts_pkg::CfgTimeSlice:  time_slice_q  <= cfg_wdata_i[SW-1:0];
        rrts_pkg::CfgTickPeriod: tick_period_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Captured request.
  logic [2:0]    func_q;
  logic [IW-1:0] id_q;
  logic          fresh_q;
  logic [MW-1:0] ms_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      func_q  <= func_i;
      id_q    <= task_id_i;
      fresh_q <= fresh_i;
      ms_q    <= sleep_ms_i;
    end
  end

  // Scheduler state.
  logic [IW-1:0] rq_q [N];
  logic [IW-1:0] rq_head_q;
  logic [LW-1:0] rq_len_q;
  logic [N-1:0]  rdy_mask_q;
  logic [N-1:0]  rdy_mask_d;
  logic [N-1:0]  slp_mask_q;
  logic [SW-1:0] slice_q [N];
  logic [IW-1:0] sl_id_q [N];
  logic [MW-1:0] sl_cnt_q [N];
  logic [LW-1:0] sl_len_q;
  logic [LW-1:0] walk_idx_q;
  logic [LW-1:0] kept_q;
  logic [IW-1:0] cur_task_q;
  logic          cur_idle_q;

  // Divider state.
  logic [MW-1:0]                 quo_q;
  logic [PW-1:0]                 rem_q;
  logic [PW-1:0]                 div_q;
  logic [rrts_pkg::DivCntW-1:0]  div_cnt_q;

  logic [IW-1:0] head_id;
  logic [IW-1:0] rq_tail;
  logic [IW-1:0] walk_id;
  logic [MW-1:0] walk_cnt;
  logic [MW-1:0] ticks;
  logic          ticks_zero;

  assign head_id    = rq_q[rq_head_q];
  assign rq_tail    = rq_head_q + rq_len_q[IW-1:0];
  assign walk_id    = sl_id_q[walk_idx_q[IW-1:0]];
  assign walk_cnt   = sl_cnt_q[walk_idx_q[IW-1:0]];
  assign ticks      = quo_q + MW'(rem_q != '0);
  assign ticks_zero = (quo_q == '0) && (rem_q == '0);

  // Queue operations requested in this cycle.
  logic          rq_pop, rq_push;
  logic [IW-1:0] push_id;
  logic          slice_we;
  logic [IW-1:0] slice_idx;
  logic [SW-1:0] slice_wdata;
  logic          sl_keep, sl_expire, sl_add;

  always_comb begin
    rq_pop      = 1'b0;
    rq_push     = 1'b0;
    push_id     = head_id;
    slice_we    = 1'b0;
    slice_idx   = head_id;
    slice_wdata = time_slice_q;
    sl_keep     = 1'b0;
    sl_expire   = 1'b0;
    sl_add      = 1'b0;
    if (cmd_i.exec) begin
      case (func_q)
        rrts_pkg::FuncReady: begin
          if (!rdy_mask_q[id_q] && !slp_mask_q[id_q] && (rq_len_q < LW'(N))) begin
            rq_push   = 1'b1;
            push_id   = id_q;
            slice_idx = id_q;
            slice_we  = fresh_q;
          end
        end
        rrts_pkg::FuncYield: begin
          if (!cur_idle_q && (rq_len_q > LW'(1))) begin
            rq_pop  = 1'b1;
            rq_push = 1'b1;
          end
        end
        rrts_pkg::FuncBlock: begin
          rq_pop = !cur_idle_q;
        end
        default: ;
      endcase
    end
    // Slice count of the running task on a tick.
    if (cmd_i.tick_slice && !cur_idle_q) begin
      slice_we = 1'b1;
      if (slice_q[head_id] <= SW'(1)) begin
        rq_pop  = 1'b1;
        rq_push = 1'b1;
      end else begin
        slice_wdata = slice_q[head_id] - SW'(1);
      end
    end
    // One sleeper per cycle during the walk.
    if (cmd_i.walk_step) begin
      if (walk_cnt <= MW'(1)) begin
        sl_expire = 1'b1;
        rq_push   = 1'b1;
        push_id   = walk_id;
      end else begin
        sl_keep = 1'b1;
      end
    end
    // Sleep of the running task once the tick count is known.
    if (cmd_i.sleep_apply && !cur_idle_q) begin
      rq_pop = 1'b1;
      if (ticks_zero) begin
        rq_push = 1'b1;
      end else begin
        sl_add = 1'b1;
      end
    end
  end

  // Ready membership: the popped head leaves, the pushed task joins.
  always_comb begin
    rdy_mask_d = rdy_mask_q;
    if (rq_pop) begin
      rdy_mask_d[head_id] = 1'b0;
    end
    if (rq_push) begin
      rdy_mask_d[push_id] = 1'b1;
    end
  end

  // Ready queue storage and slice counters.
  always_ff @(posedge clk_i) begin
    if (rq_push) begin
      rq_q[rq_tail] <= push_id;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < N; i++) begin
        slice_q[i] <= rrts_pkg::SliceRst;
      end
    end else if (slice_we) begin
      slice_q[slice_idx] <= slice_wdata;
    end
  end

  // Sleep list storage, compacted in place during the walk.
  always_ff @(posedge clk_i) begin
    if (sl_keep) begin
      sl_id_q[kept_q[IW-1:0]]  <= walk_id;
      sl_cnt_q[kept_q[IW-1:0]] <= walk_cnt - MW'(1);
    end
    if (sl_add) begin
      sl_id_q[sl_len_q[IW-1:0]]  <= head_id;
      sl_cnt_q[sl_len_q[IW-1:0]] <= ticks;
    end
  end

  // Queue pointers, membership bits and dispatch.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rq_head_q  <= '0;
      rq_len_q   <= '0;
      rdy_mask_q <= '0;
      slp_mask_q <= '0;
      sl_len_q   <= '0;
      walk_idx_q <= '0;
      kept_q     <= '0;
      cur_task_q <= '0;
      cur_idle_q <= 1'b1;
    end else begin
      if (rq_pop) begin
        rq_head_q <= rq_head_q + IW'(1);
      end
      rdy_mask_q <= rdy_mask_d;
      rq_len_q   <= rq_len_q + LW'(rq_push) - LW'(rq_pop);
      if (sl_expire) begin
        slp_mask_q[walk_id] <= 1'b0;
      end
      if (sl_add) begin
        slp_mask_q[head_id] <= 1'b1;
        sl_len_q            <= sl_len_q + LW'(1);
      end
      if (cmd_i.walk_start) begin
        walk_idx_q <= '0;
        kept_q     <= '0;
      end
      if (cmd_i.walk_step) begin
        walk_idx_q <= walk_idx_q + LW'(1);
        if (sl_keep) begin
          kept_q <= kept_q + LW'(1);
        end
      end
      if (cmd_i.walk_end) begin
        sl_len_q <= kept_q;
      end
      if (cmd_i.finish) begin
        cur_idle_q <= (rq_len_q == '0);
        cur_task_q <= (rq_len_q == '0) ? '0 : head_id;
      end
    end
  end

  // Restoring divider, one quotient bit per cycle.
  logic [PW:0] rem_shift;
  assign rem_shift = {rem_q, quo_q[MW-1]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_cnt_q <= '0;
    end else if (cmd_i.div_start) begin
      div_cnt_q <= rrts_pkg::DivCntW'(MW);
    end else if (cmd_i.div_step) begin
      div_cnt_q <= div_cnt_q - rrts_pkg::DivCntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_start) begin
      quo_q <= ms_q;
      rem_q <= '0;
      div_q <= (tick_period_q == '0) ? PW'(1) : tick_period_q;
    end else if (cmd_i.div_step) begin
      if (rem_shift >= {1'b0, div_q}) begin
        rem_q <= PW'(rem_shift - {1'b0, div_q});
        quo_q <= {quo_q[MW-2:0], 1'b1};
      end else begin
        rem_q <= rem_shift[PW-1:0];
        quo_q <= {quo_q[MW-2:0], 1'b0};
      end
    end
  end

  // Result registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      running_task_o    <= (rq_len_q == '0) ? '0 : head_id;
      running_is_idle_o <= (rq_len_q == '0);
      switched_o        <= (cur_idle_q != (rq_len_q == '0)) ||
                           ((rq_len_q != '0) && (cur_task_q != head_id));
      ready_count_o     <= rq_len_q;
    end
  end

  assign status_o.is_tick   = (func_q == rrts_pkg::FuncTick);
  assign status_o.is_sleep  = (func_q == rrts_pkg::FuncSleep);
  assign status_o.walk_done = (walk_idx_q == sl_len_q);
  assign status_o.div_done  = (div_cnt_q == '0);

endmodule

### rtl/round_robin_task_scheduler.sv
// Top level of the round-robin task scheduler.
// Depends on rrts_pkg, rrts_ctrl and rrts_dp.
//
// One request on the input channel (func_i, task_id_i, fresh_i, sleep_ms_i)
// carries one scheduler event and yields exactly one result on the output
// channel: the running task, whether idle runs, whether it switched, and the
// ready queue length. Both channels use valid and stall.
// Each event is loaded and decoded; make ready, yield, block and unknown
// events then execute, a tick walks the sleep list one entry per cycle, and
// a sleep runs the divider, which produces one quotient bit per cycle, and
// then applies the sleep; each event then dispatches its result.
// One request is in flight at a time; the next is accepted in the cycle
// after the previous result is registered, even while that result is stalled.
// When the receiver stalls, the result holds and the next event finishes
// its work but waits for the output register before dispatching.
// Reset empties both lists, sets every slice counter and the two configuration
// registers to 10 and lets idle run. The user must write configuration through
// cfg_we_i, cfg_idx_i, cfg_wdata_i while idle; the block does not enforce it.
module round_robin_task_scheduler (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic                          cfg_idx_i,
  input  logic [rrts_pkg::PeriodW-1:0]  cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [2:0]                    func_i,
  input  logic [rrts_pkg::IdW-1:0]      task_id_i,
  input  logic                          fresh_i,
  input  logic [rrts_pkg::MsW-1:0]      sleep_ms_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [rrts_pkg::IdW-1:0]      running_task_o,
  output logic                          running_is_idle_o,
  output logic                          switched_o,
  output logic [rrts_pkg::LenW-1:0]     ready_count_o
);

  rrts_pkg::cmd_t    cmd;
  rrts_pkg::status_t status;

  // Sequencing of each event.
  rrts_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // Queues, counters and divider.
  rrts_dp u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_idx_i         (cfg_idx_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .func_i            (func_i),
    .task_id_i         (task_id_i),
    .fresh_i           (fresh_i),
    .sleep_ms_i        (sleep_ms_i),
    .cmd_i             (cmd),
    .status_o          (status),
    .running_task_o    (running_task_o),
    .running_is_idle_o (running_is_idle_o),
    .switched_o        (switched_o),
    .ready_count_o     (ready_count_o)
  );

endmodule
